[rtl/interval_relation_scan_unit_macros.svh]
// ---------------------------------------------------------------------------
// Interval relation scan unit: assertion macros
// Shared property templates for the checkers of this block.
// ---------------------------------------------------------------------------
`ifndef INTERVAL_RELATION_SCAN_UNIT_MACROS_SVH
`define INTERVAL_RELATION_SCAN_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define IRS_ASSERT_SAME(label, clk, dis, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define IRS_ASSERT_NEXT(label, clk, dis, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/irs_pkg.sv]
// ---------------------------------------------------------------------------
// Interval relation scan package
// Widths, codes and types shared by the interval relation scan modules.
// ---------------------------------------------------------------------------
package irs_pkg;

    // Default sizes of the record table.
    localparam int DEF_MAX_RECORDS = 4096;
    localparam int DEF_TIME_BITS   = 32;

    // Fixed field widths.
    localparam int MODE_W     = 2;
    localparam int KIND_W     = 5;
    localparam int FIELD_W    = 32;
    localparam int ATTR_W     = 32;
    localparam int STATUS_W   = 2;
    localparam int OUT_W      = 13;

    // Stream and register port widths.
    localparam int IN_DATA_W  = 7 * FIELD_W;
    localparam int IN_USER_W  = MODE_W + KIND_W;
    localparam int OUT_DATA_W = 32;
    localparam int OUT_USER_W = STATUS_W;
    localparam int APB_ADDR_W = 2;
    localparam int APB_DATA_W = 32;

    // Item modes.
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_APPEND = 2'd1;
    localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_NONE   = 2'd3;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_ORDER = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_RSVD  = 2'd3;

    // Register byte address of the count/XOR select.
    localparam logic [APB_ADDR_W-1:0] REG_COUNT_MATCHES = 2'd0;

    // Query predicate kinds.
    localparam logic [KIND_W-1:0] KIND_EQUALS      = 5'd0;
    localparam logic [KIND_W-1:0] KIND_STARTS      = 5'd1;
    localparam logic [KIND_W-1:0] KIND_STARTED     = 5'd2;
    localparam logic [KIND_W-1:0] KIND_FINISHES    = 5'd3;
    localparam logic [KIND_W-1:0] KIND_FINISHED    = 5'd4;
    localparam logic [KIND_W-1:0] KIND_MEETS       = 5'd5;
    localparam logic [KIND_W-1:0] KIND_MET         = 5'd6;
    localparam logic [KIND_W-1:0] KIND_OVERLAPS    = 5'd7;
    localparam logic [KIND_W-1:0] KIND_OVERLAPPED  = 5'd8;
    localparam logic [KIND_W-1:0] KIND_CONTAINS    = 5'd9;
    localparam logic [KIND_W-1:0] KIND_CONTAINED   = 5'd10;
    localparam logic [KIND_W-1:0] KIND_PRECEDES    = 5'd11;
    localparam logic [KIND_W-1:0] KIND_PRECEDED    = 5'd12;
    localparam logic [KIND_W-1:0] KIND_STAB        = 5'd13;
    localparam logic [KIND_W-1:0] KIND_OVERLAP     = 5'd14;
    localparam logic [KIND_W-1:0] KIND_OV_BETWEEN  = 5'd15;
    localparam logic [KIND_W-1:0] KIND_OV_ABOVE    = 5'd16;
    localparam logic [KIND_W-1:0] KIND_OV_BELOW    = 5'd17;

    // Control that travels with each record read through the scan pipeline.
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } scan_ctl_t;

endpackage

[rtl/irs_ram.sv]
// ---------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; contents have no reset.
// ---------------------------------------------------------------------------
module irs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                                      aclk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic                                      re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] store_mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            store_mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= store_mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/irs_scan.sv]
// ---------------------------------------------------------------------------
// Interval relation scan datapath
// Evaluates the query predicate on one record per cycle and folds the
// matches into a count or an XOR of record ids.
// ---------------------------------------------------------------------------
module irs_scan #(
    parameter int TIME_BITS = 32,
    parameter int ID_W      = 12,
    parameter int ACC_W     = 13
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              count_mode,
    input  logic [irs_pkg::KIND_W-1:0]        kind,
    input  logic [TIME_BITS-1:0]              q_start,
    input  logic [TIME_BITS-1:0]              q_end,
    input  logic [TIME_BITS-1:0]              q_point,
    input  logic signed [irs_pkg::ATTR_W-1:0] attr_low,
    input  logic signed [irs_pkg::ATTR_W-1:0] attr_high,
    input  logic signed [irs_pkg::ATTR_W-1:0] attr_limit,
    input  irs_pkg::scan_ctl_t                rec_ctl,
    input  logic [ID_W-1:0]                   rec_id,
    input  logic [TIME_BITS-1:0]              rec_start,
    input  logic [TIME_BITS-1:0]              rec_end,
    input  logic signed [irs_pkg::ATTR_W-1:0] rec_attr,
    output logic                              done,
    output logic [ACC_W-1:0]                  result
);
    import irs_pkg::*;

    logic       ov;
    logic       hit;
    scan_ctl_t  ctl_reg;
    logic       hit_reg;
    logic [ID_W-1:0]  id_reg;
    logic [ACC_W-1:0] acc_reg;
    logic [ACC_W-1:0] acc_next;
    logic       done_reg;

    // Predicate of the record against the query.
    always_comb begin
        ov = (rec_start <= q_end) && (q_start <= rec_end);
        unique case (kind)
            KIND_EQUALS:     hit = (rec_start == q_start) && (rec_end == q_end);
            KIND_STARTS:     hit = (rec_start == q_start) && (rec_end > q_end);
            KIND_STARTED:    hit = (rec_start == q_start) && (rec_end < q_end);
            KIND_FINISHES:   hit = (rec_end == q_end) && (rec_start < q_start);
            KIND_FINISHED:   hit = (rec_end == q_end) && (rec_start > q_start);
            KIND_MEETS:      hit = (rec_start == q_end);
            KIND_MET:        hit = (rec_end == q_start);
            KIND_OVERLAPS:   hit = (q_start < rec_start) && (rec_start < q_end)
                                   && (q_end < rec_end);
            KIND_OVERLAPPED: hit = (q_start > rec_start) && (q_start < rec_end)
                                   && (q_end > rec_end);
            KIND_CONTAINS:   hit = (rec_start > q_start) && (rec_end < q_end);
            KIND_CONTAINED:  hit = (rec_start < q_start) && (rec_end > q_end);
            KIND_PRECEDES:   hit = (rec_start > q_end);
            KIND_PRECEDED:   hit = (rec_end < q_start);
            KIND_STAB:       hit = (rec_start <= q_point) && (q_point <= rec_end);
            KIND_OVERLAP:    hit = ov;
            KIND_OV_BETWEEN: hit = ov && (rec_attr > attr_low) && (rec_attr < attr_high);
            KIND_OV_ABOVE:   hit = ov && (rec_attr > attr_limit);
            KIND_OV_BELOW:   hit = ov && (rec_attr < attr_limit);
            default:         hit = 1'b0;
        endcase
    end

    // Fold stage: a new scan starts from zero on its first record.
    always_comb begin
        acc_next = ctl_reg.first ? '0 : acc_reg;
        if (hit_reg) begin
            if (count_mode) begin
                acc_next = acc_next + ACC_W'(1);
            end else begin
                acc_next = acc_next ^ ACC_W'(id_reg);
            end
        end
    end

    // Match register, then accumulator and completion flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            ctl_reg  <= rec_ctl;
            done_reg <= ctl_reg.valid && ctl_reg.last;
        end
        hit_reg <= hit;
        id_reg  <= rec_id;
        if (ctl_reg.valid) begin
            acc_reg <= acc_next;
        end
    end

    assign done   = done_reg;
    assign result = acc_reg;

endmodule

[rtl/interval_relation_scan_unit.sv]
// ---------------------------------------------------------------------------
// Interval relation scan unit
// Record table of time intervals with append, clear and predicate scans.
// ---------------------------------------------------------------------------
// Input beats arrive on the s_ stream: tuser carries the mode and the query
// kind, tdata the times and attributes. Every input beat gives exactly one
// result beat on the m_ stream with the answer, a status and the number of
// stored records. The APB port holds one register that selects between a
// match count and an XOR of matching record ids.
// Clear, append and unused modes answer in the cycle after acceptance.
// A query reads the record memory one entry per cycle and then waits in
// the drain state until the scan datapath flags completion; an empty
// table answers like a clear. The single read port of the record memory
// sets this rate. One item is in the block at a time.
// The result sits in an output register; a new beat is accepted while it
// is being taken. When the receiver stalls, the result holds and s_tready
// stays low until it is taken.
// Reset empties the table and selects XOR answers; the record memory is
// not cleared, as only entries below the fill level are ever read.
// ---------------------------------------------------------------------------
module interval_relation_scan_unit #(
    parameter int MAX_RECORDS = irs_pkg::DEF_MAX_RECORDS,
    parameter int TIME_BITS   = irs_pkg::DEF_TIME_BITS
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Input stream.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // tdata: start_time, end_time, stab_point, second_attr, attr_low,
    // attr_high, attr_limit
    input  logic [irs_pkg::IN_DATA_W-1:0]     s_tdata,
    // tuser: mode, query_kind
    input  logic [irs_pkg::IN_USER_W-1:0]     s_tuser,
    // Result stream.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // tdata: answer, record_count, zero fill
    output logic [irs_pkg::OUT_DATA_W-1:0]    m_tdata,
    // tuser: status
    output logic [irs_pkg::OUT_USER_W-1:0]    m_tuser,
    // Register port.
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [irs_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [irs_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [irs_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);
    import irs_pkg::*;

    localparam int FILL_W = $clog2(MAX_RECORDS + 1);
    localparam int AW     = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
    localparam int REC_W  = 2 * TIME_BITS + ATTR_W;
    localparam int XW     = (FILL_W > OUT_W) ? FILL_W : OUT_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN
    } state_t;

    // Input field unpacking.
    logic [MODE_W-1:0]    in_mode;
    logic [KIND_W-1:0]    in_kind;
    logic [63:0]          in_start_w;
    logic [63:0]          in_end_w;
    logic [63:0]          in_point_w;
    logic [TIME_BITS-1:0] in_start;
    logic [TIME_BITS-1:0] in_end;
    logic [TIME_BITS-1:0] in_point;
    logic [ATTR_W-1:0]    in_attr;
    logic [ATTR_W-1:0]    in_low;
    logic [ATTR_W-1:0]    in_high;
    logic [ATTR_W-1:0]    in_limit;

    assign in_mode    = s_tuser[MODE_W-1:0];
    assign in_kind    = s_tuser[MODE_W +: KIND_W];
    assign in_start_w = {32'd0, s_tdata[0*FIELD_W +: FIELD_W]};
    assign in_end_w   = {32'd0, s_tdata[1*FIELD_W +: FIELD_W]};
    assign in_point_w = {32'd0, s_tdata[2*FIELD_W +: FIELD_W]};
    assign in_start   = in_start_w[TIME_BITS-1:0];
    assign in_end     = in_end_w[TIME_BITS-1:0];
    assign in_point   = in_point_w[TIME_BITS-1:0];
    assign in_attr    = s_tdata[3*FIELD_W +: FIELD_W];
    assign in_low     = s_tdata[4*FIELD_W +: FIELD_W];
    assign in_high    = s_tdata[5*FIELD_W +: FIELD_W];
    assign in_limit   = s_tdata[6*FIELD_W +: FIELD_W];

    // Registers.
    state_t               state_reg,     state_next;
    logic [FILL_W-1:0]    fill_reg,      fill_next;
    logic [FILL_W-1:0]    scan_cnt_reg,  scan_cnt_next;
    logic                 out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]     answer_reg,    answer_next;
    logic [STATUS_W-1:0]  status_reg,    status_next;
    logic [OUT_W-1:0]     count_reg,     count_next;
    scan_ctl_t            issue_ctl_reg, issue_ctl_next;
    logic [AW-1:0]        issue_id_reg;
    logic                 count_mode_reg;
    logic                 load_query;
    logic [KIND_W-1:0]    kind_reg;
    logic [TIME_BITS-1:0] q_start_reg;
    logic [TIME_BITS-1:0] q_end_reg;
    logic [TIME_BITS-1:0] q_point_reg;
    logic [ATTR_W-1:0]    q_low_reg;
    logic [ATTR_W-1:0]    q_high_reg;
    logic [ATTR_W-1:0]    q_limit_reg;

    // Memory and scan signals.
    logic                 ram_we;
    logic                 ram_re;
    logic [REC_W-1:0]     ram_wdata;
    logic [REC_W-1:0]     ram_rdata;
    logic                 scan_done;
    logic [FILL_W-1:0]    scan_result;
    logic [FILL_W-1:0]    scan_cnt_inc;
    logic [XW-1:0]        fill_wide;
    logic [XW-1:0]        result_wide;
    logic                 in_fire;
    logic                 cfg_write;

    assign s_tready = (state_reg == ST_IDLE) && (!out_valid_reg || m_tready);
    assign in_fire  = s_tvalid && s_tready;

    assign scan_cnt_inc = scan_cnt_reg + FILL_W'(1);
    assign fill_wide    = XW'(fill_next);
    assign result_wide  = XW'(scan_result);
    assign ram_wdata    = {in_attr, in_end, in_start};

    // Item handling and scan sequencing.
    always_comb begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        scan_cnt_next  = scan_cnt_reg;
        out_valid_next = out_valid_reg && !m_tready;
        answer_next    = answer_reg;
        status_next    = status_reg;
        count_next     = count_reg;
        issue_ctl_next = '0;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        load_query     = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    answer_next    = '0;
                    status_next    = STAT_OK;
                    out_valid_next = 1'b1;
                    unique case (in_mode)
                        MODE_CLEAR: begin
                            fill_next = '0;
                        end
                        MODE_APPEND: begin
                            if (in_start > in_end) begin
                                status_next = STAT_ORDER;
                            end else if (fill_reg == FILL_W'(MAX_RECORDS)) begin
                                status_next = STAT_FULL;
                            end else begin
                                ram_we    = 1'b1;
                                fill_next = fill_reg + FILL_W'(1);
                            end
                        end
                        MODE_QUERY: begin
                            if (fill_reg != '0) begin
                                out_valid_next = 1'b0;
                                load_query     = 1'b1;
                                scan_cnt_next  = '0;
                                state_next     = ST_SCAN;
                            end
                        end
                        MODE_NONE: begin
                        end
                    endcase
                    count_next = fill_wide[OUT_W-1:0];
                end
            end
            ST_SCAN: begin
                ram_re               = 1'b1;
                issue_ctl_next.valid = 1'b1;
                issue_ctl_next.first = (scan_cnt_reg == '0);
                issue_ctl_next.last  = (scan_cnt_inc == fill_reg);
                scan_cnt_next        = scan_cnt_inc;
                if (scan_cnt_inc == fill_reg) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (scan_done) begin
                    out_valid_next = 1'b1;
                    answer_next    = result_wide[OUT_W-1:0];
                    status_next    = STAT_OK;
                    count_next     = fill_wide[OUT_W-1:0];
                    state_next     = ST_IDLE;
                end
            end
        endcase
    end

    // State, table fill level and result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            scan_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
            issue_ctl_reg <= '0;
        end else begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            scan_cnt_reg  <= scan_cnt_next;
            out_valid_reg <= out_valid_next;
            issue_ctl_reg <= issue_ctl_next;
        end
        answer_reg   <= answer_next;
        status_reg   <= status_next;
        count_reg    <= count_next;
        issue_id_reg <= scan_cnt_reg[AW-1:0];
        if (load_query) begin
            kind_reg    <= in_kind;
            q_start_reg <= in_start;
            q_end_reg   <= in_end;
            q_point_reg <= in_point;
            q_low_reg   <= in_low;
            q_high_reg  <= in_high;
            q_limit_reg <= in_limit;
        end
    end

    // Configuration register; the port has a single register.
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_mode_reg <= 1'b0;
        end else if (cfg_write) begin
            count_mode_reg <= pwdata[0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == REG_COUNT_MATCHES) ?
                    {{(APB_DATA_W-1){1'b0}}, count_mode_reg} : '0;

    // Record memory: attribute, end and start packed in one word.
    irs_ram #(
        .WIDTH (REC_W),
        .DEPTH (MAX_RECORDS)
    ) u_irs_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (fill_reg[AW-1:0]),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (scan_cnt_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    // Predicate and fold datapath.
    irs_scan #(
        .TIME_BITS (TIME_BITS),
        .ID_W      (AW),
        .ACC_W     (FILL_W)
    ) u_irs_scan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .count_mode (count_mode_reg),
        .kind       (kind_reg),
        .q_start    (q_start_reg),
        .q_end      (q_end_reg),
        .q_point    (q_point_reg),
        .attr_low   ($signed(q_low_reg)),
        .attr_high  ($signed(q_high_reg)),
        .attr_limit ($signed(q_limit_reg)),
        .rec_ctl    (issue_ctl_reg),
        .rec_id     (issue_id_reg),
        .rec_start  (ram_rdata[TIME_BITS-1:0]),
        .rec_end    (ram_rdata[TIME_BITS +: TIME_BITS]),
        .rec_attr   ($signed(ram_rdata[2*TIME_BITS +: ATTR_W])),
        .done       (scan_done),
        .result     (scan_result)
    );

    // Result beat.
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W - 2*OUT_W){1'b0}}, count_reg, answer_reg};
    assign m_tuser  = status_reg;

endmodule

[rtl/irs_checker.sv]
// ---------------------------------------------------------------------------
// Interval relation scan checker
// Port-level properties of the scan unit, bound to the top level.
// ---------------------------------------------------------------------------
`include "interval_relation_scan_unit_macros.svh"

module irs_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [irs_pkg::OUT_DATA_W-1:0]    m_tdata,
    input  logic [irs_pkg::OUT_USER_W-1:0]    m_tuser
);
    import irs_pkg::*;

    // A stalled result beat keeps its contents.
    `IRS_ASSERT_NEXT(a_hold, aclk, !aresetn, m_tvalid && !m_tready,
        $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

    // A rejected append never carries an answer.
    `IRS_ASSERT_SAME(a_reject_zero, aclk, !aresetn, m_tvalid && (m_tuser != STAT_OK),
        m_tdata[OUT_W-1:0] == '0, "rejected item with nonzero answer")

    // The reserved status code is never produced.
    `IRS_ASSERT_SAME(a_status_code, aclk, !aresetn, m_tvalid, m_tuser != STAT_RSVD,
        "reserved status code")

    // No result beat is offered right after reset.
    `IRS_ASSERT_NEXT(a_reset_idle, aclk, 1'b0, !aresetn, !m_tvalid,
        "result valid after reset")

endmodule

bind interval_relation_scan_unit irs_checker u_irs_checker (.*);

[tb/interval_relation_scan_unit_tb.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Interval relation scan unit testbench
// Streams clear, append and query beats into the block and scores every
// result beat against a cycle-free model of the record table. A short
// directed table covers the field extremes, every predicate kind and the
// ordering rejection. Random phases with sender gaps and receiver stalls
// follow, one of them with a long receiver hold-off, then a pass over a
// freshly built table in both answer modes and a final drain.
// ---------------------------------------------------------------------------
module interval_relation_scan_unit_tb;
    import irs_pkg::*;

    localparam int MAX_REC = DEF_MAX_RECORDS;
    // The slowest correct run is about 140 beats, each scan over a small
    // table even under the heaviest stalls, plus one long hold-off.
    // This limit leaves many times that margin.
    localparam int CYCLE_LIMIT = 600000;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = MAX_REC + 16;
    localparam int ITEMS_PER_PHASE = 25;
    localparam int FILL_ITEMS = 8;
    localparam logic [KIND_W-1:0] KIND_TOP_UNUSED = 5'd31;
    localparam logic [FIELD_W-1:0] T_MAX = 32'hFFFF_FFFF;
    localparam logic signed [ATTR_W-1:0] A_MIN = 32'sh8000_0000;
    localparam logic signed [ATTR_W-1:0] A_MAX = 32'sh7FFF_FFFF;

    typedef struct packed {
        logic [MODE_W-1:0]        mode;
        logic [KIND_W-1:0]        kind;
        logic [FIELD_W-1:0]       start_time;
        logic [FIELD_W-1:0]       end_time;
        logic [FIELD_W-1:0]       stab_point;
        logic signed [ATTR_W-1:0] second_attr;
        logic signed [ATTR_W-1:0] attr_low;
        logic signed [ATTR_W-1:0] attr_high;
        logic signed [ATTR_W-1:0] attr_limit;
    } scan_item_t;

    typedef struct packed {
        logic [OUT_W-1:0]    answer;
        logic [STATUS_W-1:0] status;
        logic [OUT_W-1:0]    record_count;
    } scan_result_t;

    // One row of the directed table; typed rows carry a hand-written answer.
    typedef struct {
        scan_item_t   item;
        bit           typed;
        scan_result_t res;
    } dir_row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [IN_USER_W-1:0]  s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [OUT_USER_W-1:0] m_tuser;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Model of the record table and the count/XOR select.
    logic [FIELD_W-1:0]       tab_start [MAX_REC];
    logic [FIELD_W-1:0]       tab_end [MAX_REC];
    logic signed [ATTR_W-1:0] tab_attr [MAX_REC];
    int unsigned              tab_fill = 0;
    bit                       count_sel = 1'b0;

    scan_result_t pending_results[$];
    int           fail_count = 0;
    int unsigned  cycle_count = 0;
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;
    int           hold_token = 0;
    int           hold_seen = 0;
    int           hold_left = 0;

    interval_relation_scan_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Predicate of one stored record against the query of a beat.
    function automatic bit relation_holds(input logic [KIND_W-1:0] kind,
                                          input logic [FIELD_W-1:0] s,
                                          input logic [FIELD_W-1:0] e,
                                          input logic signed [ATTR_W-1:0] a,
                                          input scan_item_t q);
        logic [FIELD_W-1:0]       qs;
        logic [FIELD_W-1:0]       qe;
        logic [FIELD_W-1:0]       p;
        logic signed [ATTR_W-1:0] lo;
        logic signed [ATTR_W-1:0] hi;
        logic signed [ATTR_W-1:0] lim;
        bit                       ov;
        qs  = q.start_time;
        qe  = q.end_time;
        p   = q.stab_point;
        lo  = q.attr_low;
        hi  = q.attr_high;
        lim = q.attr_limit;
        ov  = (s <= qe) && (qs <= e);
        case (kind)
            KIND_EQUALS:     return s == qs && e == qe;
            KIND_STARTS:     return s == qs && e > qe;
            KIND_STARTED:    return s == qs && e < qe;
            KIND_FINISHES:   return e == qe && s < qs;
            KIND_FINISHED:   return e == qe && s > qs;
            KIND_MEETS:      return s == qe;
            KIND_MET:        return e == qs;
            KIND_OVERLAPS:   return qs < s && s < qe && qe < e;
            KIND_OVERLAPPED: return qs > s && qs < e && qe > e;
            KIND_CONTAINS:   return s > qs && e < qe;
            KIND_CONTAINED:  return s < qs && e > qe;
            KIND_PRECEDES:   return s > qe;
            KIND_PRECEDED:   return e < qs;
            KIND_STAB:       return s <= p && p <= e;
            KIND_OVERLAP:    return ov;
            KIND_OV_BETWEEN: return ov && a > lo && a < hi;
            KIND_OV_ABOVE:   return ov && a > lim;
            KIND_OV_BELOW:   return ov && a < lim;
            default:         return 1'b0;
        endcase
    endfunction

    // Applies one accepted beat to the table model and returns its result.
    function automatic scan_result_t predict_scan(input scan_item_t it);
        scan_result_t r;
        r = '0;
        case (it.mode)
            MODE_CLEAR: tab_fill = 0;
            MODE_APPEND: begin
                if (it.start_time > it.end_time) begin
                    r.status = STAT_ORDER;
                end else if (tab_fill >= MAX_REC) begin
                    r.status = STAT_FULL;
                end else begin
                    tab_start[tab_fill] = it.start_time;
                    tab_end[tab_fill]   = it.end_time;
                    tab_attr[tab_fill]  = it.second_attr;
                    tab_fill++;
                end
            end
            MODE_QUERY: begin
                for (int i = 0; i < tab_fill; i++) begin
                    if (relation_holds(it.kind, tab_start[i], tab_end[i], tab_attr[i], it)) begin
                        if (count_sel)
                            r.answer = r.answer + 1'b1;
                        else
                            r.answer = r.answer ^ OUT_W'(i);
                    end
                end
            end
            default: ;
        endcase
        r.record_count = OUT_W'(tab_fill);
        return r;
    endfunction

    function automatic dir_row_t mk_row(input logic [MODE_W-1:0] m,
                                        input logic [KIND_W-1:0] k,
                                        input logic [FIELD_W-1:0] s,
                                        input logic [FIELD_W-1:0] e,
                                        input logic [FIELD_W-1:0] p,
                                        input logic signed [ATTR_W-1:0] a,
                                        input logic signed [ATTR_W-1:0] lo,
                                        input logic signed [ATTR_W-1:0] hi,
                                        input logic signed [ATTR_W-1:0] lim,
                                        input bit typed,
                                        input logic [OUT_W-1:0] ans,
                                        input logic [STATUS_W-1:0] st,
                                        input logic [OUT_W-1:0] cnt);
        dir_row_t row;
        row.item.mode        = m;
        row.item.kind        = k;
        row.item.start_time  = s;
        row.item.end_time    = e;
        row.item.stab_point  = p;
        row.item.second_attr = a;
        row.item.attr_low    = lo;
        row.item.attr_high   = hi;
        row.item.attr_limit  = lim;
        row.typed            = typed;
        row.res.answer       = ans;
        row.res.status       = st;
        row.res.record_count = cnt;
        return row;
    endfunction

    // Mostly small times so that records and queries relate; some extremes.
    function automatic logic [FIELD_W-1:0] rand_time();
        case ($urandom_range(19))
            0:       return '0;
            1:       return T_MAX;
            2, 3:    return $urandom();
            default: return $urandom_range(40);
        endcase
    endfunction

    function automatic logic [ATTR_W-1:0] rand_attr();
        case ($urandom_range(9))
            0:       return A_MIN;
            1:       return A_MAX;
            2, 3:    return $urandom();
            default: return $urandom_range(20) - 10;
        endcase
    endfunction

    function automatic scan_item_t random_item();
        scan_item_t it;
        int         pick;
        if ($urandom_range(9) == 0)
            it.kind = KIND_W'($urandom_range(31, 18));
        else
            it.kind = KIND_W'($urandom_range(17));
        it.start_time  = rand_time();
        it.end_time    = rand_time();
        it.stab_point  = rand_time();
        it.second_attr = rand_attr();
        it.attr_low    = rand_attr();
        it.attr_high   = rand_attr();
        it.attr_limit  = rand_attr();
        pick = $urandom_range(99);
        if (pick < 6) begin
            it.mode = MODE_CLEAR;
        end else if (pick < 50) begin
            it.mode = MODE_APPEND;
            // Most appends are well formed so the table keeps some records.
            if (pick < 44 && it.start_time > it.end_time)
                {it.start_time, it.end_time} = {it.end_time, it.start_time};
        end else if (pick < 96) begin
            it.mode = MODE_QUERY;
            if (pick < 88 && it.start_time > it.end_time)
                {it.start_time, it.end_time} = {it.end_time, it.start_time};
        end else begin
            it.mode = MODE_NONE;
        end
        return it;
    endfunction

    // Offers one beat, waits for the handshake and records what it expects.
    task automatic send_beat(input scan_item_t it, input bit typed,
                             input scan_result_t typed_res);
        scan_result_t r;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {it.attr_limit, it.attr_high, it.attr_low, it.second_attr,
                     it.stab_point, it.end_time, it.start_time};
        s_tuser  <= {it.kind, it.mode};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        r = predict_scan(it);
        pending_results.push_back(typed ? typed_res : r);
    endtask

    task automatic stop_sending();
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0)
            @(posedge aclk);
    endtask

    // One APB transfer to the count/XOR select: setup, then access.
    task automatic apb_access(input bit wr, input logic [APB_DATA_W-1:0] wdata,
                              output logic [APB_DATA_W-1:0] rdata);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= REG_COUNT_MATCHES;
        pwdata  <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready)
            @(posedge aclk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Writes the select with noise in the unused bits and reads it back.
    task automatic set_count_sel(input bit v);
        logic [APB_DATA_W-1:0] w;
        logic [APB_DATA_W-1:0] rd;
        w    = $urandom();
        w[0] = v;
        apb_access(1'b1, w, rd);
        count_sel = v;
        apb_access(1'b0, '0, rd);
        if (rd !== APB_DATA_W'(count_sel)) begin
            $error("count_matches: expected %0d, got %0d", count_sel, rd);
            fail_count++;
        end
    endtask

    // Receiver: random stalls, plus a long hold-off when one is requested.
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else if (hold_token != hold_seen) begin
            hold_seen = hold_token;
            hold_left = HOLD_CYCLES;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Score each result beat against the oldest expectation.
    always @(posedge aclk) begin : result_check
        scan_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("result beat with nothing expected: tdata %h, tuser %h",
                       m_tdata, m_tuser);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[OUT_W-1:0] !== want.answer) begin
                    $error("answer: expected %0d, got %0d", want.answer,
                           m_tdata[OUT_W-1:0]);
                    fail_count++;
                end
                if (m_tuser !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_tuser);
                    fail_count++;
                end
                if (m_tdata[2*OUT_W-1:OUT_W] !== want.record_count) begin
                    $error("record_count: expected %0d, got %0d", want.record_count,
                           m_tdata[2*OUT_W-1:OUT_W]);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** interval_relation_scan_unit: FAILED **");
            $finish;
        end
    end

    initial begin : stimulus
        scan_item_t            it;
        dir_row_t              rows[$];
        logic [APB_DATA_W-1:0] rd;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // The select comes out of reset in XOR mode.
        apb_access(1'b0, '0, rd);
        if (rd !== APB_DATA_W'(count_sel)) begin
            $error("count_matches: expected %0d, got %0d", count_sel, rd);
            fail_count++;
        end

        // Directed table: empty-table query, extreme records, a reversed
        // append, the unused mode, every predicate kind and a clear.
        rows.push_back(mk_row(MODE_QUERY, KIND_OVERLAP, 0, T_MAX, 0, 0, 0, 0, 0,
                              1, 0, STAT_OK, 0));
        rows.push_back(mk_row(MODE_APPEND, KIND_EQUALS, 0, T_MAX, 0, A_MIN, 0, 0, 0,
                              1, 0, STAT_OK, 1));
        rows.push_back(mk_row(MODE_APPEND, KIND_EQUALS, T_MAX, T_MAX, 0, A_MAX, 0, 0, 0,
                              1, 0, STAT_OK, 2));
        rows.push_back(mk_row(MODE_APPEND, KIND_EQUALS, 10, 20, 0, -5, 0, 0, 0,
                              1, 0, STAT_OK, 3));
        rows.push_back(mk_row(MODE_APPEND, KIND_EQUALS, 15, 30, 0, 7, 0, 0, 0,
                              1, 0, STAT_OK, 4));
        rows.push_back(mk_row(MODE_APPEND, KIND_EQUALS, 21, 20, 0, 1, 0, 0, 0,
                              1, 0, STAT_ORDER, 4));
        rows.push_back(mk_row(MODE_NONE, KIND_TOP_UNUSED, T_MAX, T_MAX, T_MAX, -1, -1,
                              -1, -1, 1, 0, STAT_OK, 4));
        rows.push_back(mk_row(MODE_QUERY, KIND_EQUALS, 10, 20, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk_row(MODE_QUERY, KIND_STARTS, 10, 15, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk_row(MODE_QUERY, KIND_STARTED, 15, 40, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk_row(MODE_QUERY, KIND_FINISHES, 12, 20, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk_row(MODE_QUERY, KIND_FINISHED, 5, 30, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk_row(MODE_QUERY, KIND_MEETS, 5, 15, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk_row(MODE_QUERY, KIND_MET, 20, 25, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk_row(MODE_QUERY, KIND_OVERLAPS, 5, 17, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk_row(MODE_QUERY, KIND_OVERLAPPED, 18, 25, 0, 0, 0, 0, 0,
                              0, 0, 0, 0));
        rows.push_back(mk_row(MODE_QUERY, KIND_CONTAINS, 5, 35, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk_row(MODE_QUERY, KIND_CONTAINED, 12, 18, 0, 0, 0, 0, 0,
                              0, 0, 0, 0));
        rows.push_back(mk_row(MODE_QUERY, KIND_PRECEDES, 0, 9, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk_row(MODE_QUERY, KIND_PRECEDED, 25, 40, 0, 0, 0, 0, 0,
                              0, 0, 0, 0));
        rows.push_back(mk_row(MODE_QUERY, KIND_STAB, 0, 0, 15, 0, 0, 0, 0, 0, 0, 0, 0));
        // Reversed query interval: the predicate is applied as written.
        rows.push_back(mk_row(MODE_QUERY, KIND_OVERLAP, 25, 12, 0, 0, 0, 0, 0,
                              0, 0, 0, 0));
        rows.push_back(mk_row(MODE_QUERY, KIND_OV_BETWEEN, 0, T_MAX, 0, 0, -6, 8, 0,
                              0, 0, 0, 0));
        rows.push_back(mk_row(MODE_QUERY, KIND_OV_ABOVE, 0, T_MAX, 0, 0, 0, 0, 0,
                              0, 0, 0, 0));
        rows.push_back(mk_row(MODE_QUERY, KIND_OV_BELOW, 0, T_MAX, 0, 0, 0, 0, 0,
                              0, 0, 0, 0));
        // A kind past the last predicate matches nothing.
        rows.push_back(mk_row(MODE_QUERY, KIND_TOP_UNUSED, 0, T_MAX, 0, 0, 0, 0, 0,
                              1, 0, STAT_OK, 4));
        rows.push_back(mk_row(MODE_CLEAR, KIND_EQUALS, 0, 0, 0, 0, 0, 0, 0,
                              1, 0, STAT_OK, 0));
        foreach (rows[i])
            send_beat(rows[i].item, rows[i].typed, rows[i].res);
        stop_sending();
        wait_drained();

        // Random phases, each with its own idling pattern and select value.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
                default: begin send_idle_pct = 29; recv_stall_pct = 29; end
            endcase
            set_count_sel(ph % 2 == 0);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // Long receiver hold-off while beats keep coming.
                if (ph == 2 && n == 10)
                    hold_token++;
                // Sender pauses until the block has answered everything.
                if (ph == 1 && n == 17) begin
                    stop_sending();
                    wait_drained();
                end
                send_beat(random_item(), 1'b0, '0);
            end
            stop_sending();
            wait_drained();
        end

        // Build a small table in count mode, hit the ordering rejection and
        // scan it.
        send_idle_pct  = 0;
        recv_stall_pct = 29;
        set_count_sel(1'b1);
        it = random_item();
        it.mode = MODE_CLEAR;
        send_beat(it, 1'b0, '0);
        for (int n = 0; n < FILL_ITEMS; n++) begin
            it = random_item();
            it.mode       = MODE_APPEND;
            it.start_time = $urandom_range(1000);
            it.end_time   = it.start_time + $urandom_range(50);
            send_beat(it, 1'b0, '0);
        end
        // Start after end reports the ordering error.
        it.start_time = 100;
        it.end_time   = 99;
        send_beat(it, 1'b0, '0);
        it = random_item();
        it.mode       = MODE_QUERY;
        it.kind       = KIND_OVERLAP;
        it.start_time = 0;
        it.end_time   = T_MAX;
        send_beat(it, 1'b0, '0);
        for (int n = 0; n < 2; n++) begin
            it = random_item();
            it.mode       = MODE_QUERY;
            it.kind       = KIND_W'($urandom_range(17));
            it.start_time = $urandom_range(1000);
            it.end_time   = it.start_time + $urandom_range(100);
            it.stab_point = $urandom_range(1000);
            send_beat(it, 1'b0, '0);
        end
        stop_sending();
        wait_drained();

        set_count_sel(1'b0);
        it = random_item();
        it.mode       = MODE_QUERY;
        it.kind       = KIND_OVERLAP;
        it.start_time = 0;
        it.end_time   = T_MAX;
        send_beat(it, 1'b0, '0);
        it.kind       = KIND_OV_BETWEEN;
        it.start_time = $urandom_range(1000);
        it.end_time   = it.start_time + $urandom_range(100);
        send_beat(it, 1'b0, '0);
        it.mode = MODE_CLEAR;
        send_beat(it, 1'b0, '0);

        // Drain, then give the block time to show any stray beat.
        stop_sending();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0 && pending_results.size() == 0)
            $display("** interval_relation_scan_unit: PASSED **");
        else
            $display("** interval_relation_scan_unit: FAILED **");
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl
rtl/irs_pkg.sv
rtl/irs_ram.sv
rtl/irs_scan.sv
rtl/interval_relation_scan_unit.sv
rtl/irs_checker.sv
tb/interval_relation_scan_unit_tb.sv
